// ===== hw/rtl/owtr_pkg.sv =====
// Shared types and constants for the 1-Wire temperature reader.
package owtr_pkg;

  localparam int CNT_W     = 20;
  localparam int DEF_BYTES = 9;

  localparam logic [CNT_W-1:0] DEF_CONV_WAIT = 20'd750000;

  // sequence phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_RST1 = 3'd1;
  localparam logic [2:0] PH_WR1  = 3'd2;
  localparam logic [2:0] PH_WAIT = 3'd3;
  localparam logic [2:0] PH_RST2 = 3'd4;
  localparam logic [2:0] PH_WR2  = 3'd5;
  localparam logic [2:0] PH_READ = 3'd6;

  // bus commands
  localparam logic [7:0] CMD_SKIP    = 8'hCC;
  localparam logic [7:0] CMD_CONVERT = 8'h44;
  localparam logic [7:0] CMD_READPAD = 8'hBE;

  // slot timing in microsecond ticks
  localparam logic [CNT_W-1:0] RST_LOW    = 20'd500;
  localparam logic [CNT_W-1:0] RST_SAMPLE = 20'd570;
  localparam logic [CNT_W-1:0] RST_LEN    = 20'd1000;
  localparam logic [CNT_W-1:0] WR1_LOW    = 20'd6;
  localparam logic [CNT_W-1:0] WR0_LOW    = 20'd60;
  localparam logic [CNT_W-1:0] SLOT_LEN   = 20'd70;
  localparam logic [CNT_W-1:0] RD_LOW     = 20'd6;
  localparam logic [CNT_W-1:0] RD_SAMPLE  = 20'd15;

  typedef struct packed {
    logic [2:0]       phase;
    logic [CNT_W-1:0] cnt;
    logic [2:0]       bitp;
    logic [3:0]       bytep;
    logic [7:0]       shift;
    logic [7:0]       tlo;
    logic [7:0]       thi;
    logic             ok;
  } seq_state_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               read_ok;
    logic signed [15:0] temperature_raw;
  } result_t;

endpackage

// ===== hw/rtl/owtr_step.sv =====
// Next-state and result logic for one item of the 1-Wire read sequencer.
module owtr_step import owtr_pkg::*; #(
  parameter int SCRATCHPAD_BYTES = DEF_BYTES
) (
  input  seq_state_t       st,
  input  logic             action,
  input  logic             line_level,
  input  logic [CNT_W-1:0] conv_wait,
  output seq_state_t       st_nxt,
  output result_t          res
);

  localparam logic [4:0] NBYTES = 5'(SCRATCHPAD_BYTES);

  function automatic logic drive_of(input seq_state_t s);
    logic d;
    d = 1'b0;
    unique case (s.phase) inside
      PH_RST1, PH_RST2: d = (s.cnt < RST_LOW);
      PH_WR1, PH_WR2:   d = (s.cnt < (s.shift[0] ? WR1_LOW : WR0_LOW));
      PH_READ:          d = (s.cnt < RD_LOW);
      default:          d = 1'b0;
    endcase
    return d;
  endfunction

  seq_state_t       s;
  logic             drive;
  logic             done;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] slen;
  logic [2:0]       bitp_inc;
  logic [4:0]       bytep_inc;

  always_comb begin
    s         = st;
    drive     = 1'b0;
    done      = 1'b0;
    cnt_inc   = st.cnt + 1'b1;
    bitp_inc  = st.bitp + 1'b1;
    bytep_inc = {1'b0, st.bytep} + 5'd1;
    unique case (st.phase) inside
      PH_RST1, PH_RST2: slen = RST_LEN;
      PH_WAIT:          slen = (conv_wait == '0) ? CNT_W'(1) : conv_wait;
      default:          slen = SLOT_LEN;
    endcase

    if (action) begin
      if (st.phase == PH_IDLE) begin
        s.phase = PH_RST1;
        s.cnt   = '0;
        s.bitp  = '0;
        s.bytep = '0;
        s.shift = '0;
      end
      drive = drive_of(s);
    end else begin
      drive = drive_of(st);
      if (st.phase != PH_IDLE) begin
        // bus sampling points
        if ((st.phase == PH_RST1 || st.phase == PH_RST2) && st.cnt == RST_SAMPLE)
          s.shift = {7'd0, line_level};
        else if (st.phase == PH_READ && st.cnt == RD_SAMPLE)
          s.shift = {line_level, st.shift[7:1]};
        s.cnt = cnt_inc;
        if (cnt_inc >= slen || cnt_inc == '0) begin
          s.cnt = '0;
          unique case (st.phase) inside
            PH_RST1, PH_RST2: begin
              if (s.shift[0]) begin
                // no presence pulse: abort
                s.phase = PH_IDLE;
                s.bitp  = '0;
                s.bytep = '0;
                s.shift = '0;
                s.ok    = 1'b0;
                done    = 1'b1;
              end else begin
                s.phase = (st.phase == PH_RST1) ? PH_WR1 : PH_WR2;
                s.bitp  = '0;
                s.bytep = '0;
                s.shift = CMD_SKIP;
              end
            end
            PH_WR1, PH_WR2: begin
              s.shift = {1'b0, st.shift[7:1]};
              s.bitp  = bitp_inc;
              if (bitp_inc == '0) begin
                if (st.bytep == '0) begin
                  s.bytep = 4'd1;
                  s.shift = (st.phase == PH_WR1) ? CMD_CONVERT : CMD_READPAD;
                end else if (st.phase == PH_WR1) begin
                  s.phase = PH_WAIT;
                  s.bytep = '0;
                  s.shift = '0;
                end else begin
                  s.phase = PH_READ;
                  s.bytep = '0;
                  s.shift = '0;
                end
              end
            end
            PH_WAIT: begin
              s.phase = PH_RST2;
              s.shift = '0;
            end
            PH_READ: begin
              s.bitp = bitp_inc;
              if (bitp_inc == '0) begin
                if (st.bytep == 4'd0) s.tlo = s.shift;
                else if (st.bytep == 4'd1) s.thi = s.shift;
                if (bytep_inc >= NBYTES) begin
                  s.phase = PH_IDLE;
                  s.bitp  = '0;
                  s.bytep = '0;
                  s.shift = '0;
                  s.ok    = 1'b1;
                  done    = 1'b1;
                end else begin
                  s.bytep = bytep_inc[3:0];
                  s.shift = '0;
                end
              end
            end
            default: begin
              s.phase = PH_IDLE;
              s.bitp  = '0;
              s.bytep = '0;
              s.shift = '0;
              s.ok    = 1'b0;
            end
          endcase
        end
      end
    end
  end

  assign st_nxt              = s;
  assign res.drive_low       = drive;
  assign res.busy_res        = (s.phase != PH_IDLE);
  assign res.done_res        = done;
  assign res.read_ok         = s.ok;
  assign res.temperature_raw = signed'({s.thi, s.tlo});

endmodule

// ===== hw/rtl/owtr_out_reg.sv =====
// Result register between the sequencer and the output channel.
module owtr_out_reg import owtr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    can_load,
  output result_t data
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign data      = data_r;

endmodule

// ===== hw/rtl/onewire_temperature_reader.sv =====
// Top level: 1-Wire bus master that reads a temperature sensor tick by tick.
// The result of an accepted item is held in the output register from the next cycle.
// Throughput: one item per cycle; in_ready drops only while a result is stalled.
// Sequencer state advances in the same cycle the item is accepted.
// Reset (rst_n low, synchronous): sequencer idle, counters and bytes zero,
// conversion wait back to 750000 us, output register empty.
module onewire_temperature_reader import owtr_pkg::*; #(
  parameter int SCRATCHPAD_BYTES = DEF_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  // item channel: tick or start request
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic               in_line_level,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_drive_low,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic               out_read_ok,
  output logic signed [15:0] out_temperature_raw,
  // conversion wait register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_conversion_wait_us
);

  seq_state_t       st_r;
  seq_state_t       st_nxt;
  result_t          step_res;
  result_t          out_data;
  logic [CNT_W-1:0] conv_wait_r;
  logic             can_load;
  logic             in_acc;

  // config is always writable; the user must write it only while idle (not enforced here)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_wait_r <= DEF_CONV_WAIT;
    end else if (cfg_valid) begin
      conv_wait_r <= cfg_conversion_wait_us;
    end
  end

  // an item is taken whenever the result register can take its result
  assign in_ready = can_load;
  assign in_acc   = in_valid && can_load;

  owtr_step #(
    .SCRATCHPAD_BYTES(SCRATCHPAD_BYTES)
  ) u_step (
    .st         (st_r),
    .action     (in_action),
    .line_level (in_line_level),
    .conv_wait  (conv_wait_r),
    .st_nxt     (st_nxt),
    .res        (step_res)
  );

  // sequencer state: phase, slot counter, bit/byte positions, shift, bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  owtr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .load_data (step_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .data      (out_data)
  );

  assign out_drive_low       = out_data.drive_low;
  assign out_busy_res        = out_data.busy_res;
  assign out_done_res        = out_data.done_res;
  assign out_read_ok         = out_data.read_ok;
  assign out_temperature_raw = out_data.temperature_raw;

endmodule

// ===== hw/rtl/owtr_checker.sv =====
// Port-level assertions for the 1-Wire temperature reader, bound to the top level.
module owtr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_busy_res,
  input logic               out_done_res,
  input logic signed [15:0] out_temperature_raw
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temperature_raw)
      && $stable(out_done_res) && $stable(out_busy_res))
    else $error("stalled result changed");

  // every accepted item yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // no new item while the result register is full and stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item accepted over a stalled result");

  // a finished read leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done with busy set");

endmodule

bind onewire_temperature_reader owtr_checker u_owtr_checker (.*);

// ===== verif/owtr_result_check.sv =====
// Watches the reader's channels, predicts every result and compares it field by field.
module owtr_result_check import owtr_pkg::*; #(
  parameter int N_BYTES = DEF_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_action,
  input  logic               in_line_level,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_drive_low,
  input  logic               out_busy_res,
  input  logic               out_done_res,
  input  logic               out_read_ok,
  input  logic signed [15:0] out_temperature_raw,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_conversion_wait_us,
  output int                 pending,
  output int                 fail_count
);

  // shadow of the sequencer
  logic [2:0]       phase;
  logic [CNT_W-1:0] usec;
  logic [2:0]       bit_idx;
  logic [3:0]       byte_idx;
  logic [7:0]       shreg;
  logic [7:0]       temp_lo;
  logic [7:0]       temp_hi;
  logic             last_ok;
  logic [CNT_W-1:0] conv_wait;

  result_t reader_results_q[$];
  result_t want;
  int      n_checked;

  initial begin
    fail_count = 0;
    pending    = 0;
    n_checked  = 0;
  end

  function automatic logic bus_driven();
    case (phase)
      PH_RST1, PH_RST2: return usec < RST_LOW;
      PH_WR1, PH_WR2:   return usec < (shreg[0] ? WR1_LOW : WR0_LOW);
      PH_READ:          return usec < RD_LOW;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] slot_ticks();
    case (phase)
      PH_RST1, PH_RST2: return RST_LEN;
      PH_WAIT:          return (conv_wait == '0) ? CNT_W'(1) : conv_wait;
      default:          return SLOT_LEN;
    endcase
  endfunction

  function automatic void finish_read(logic ok);
    phase    = PH_IDLE;
    usec     = '0;
    bit_idx  = '0;
    byte_idx = '0;
    shreg    = '0;
    last_ok  = ok;
  endfunction

  function automatic void start_write(logic [2:0] ph, logic [7:0] cmd);
    phase    = ph;
    bit_idx  = '0;
    byte_idx = '0;
    shreg    = cmd;
  endfunction

  // end of a slot; returns 1 when the read sequence is over
  function automatic logic close_slot();
    usec = '0;
    case (phase)
      PH_RST1, PH_RST2: begin
        if (shreg[0]) begin
          finish_read(1'b0);
          return 1'b1;
        end
        start_write((phase == PH_RST1) ? PH_WR1 : PH_WR2, CMD_SKIP);
      end
      PH_WR1, PH_WR2: begin
        shreg   = shreg >> 1;
        bit_idx = bit_idx + 3'd1;
        if (bit_idx == '0) begin
          if (byte_idx == '0) begin
            byte_idx = 4'd1;
            shreg    = (phase == PH_WR1) ? CMD_CONVERT : CMD_READPAD;
          end else if (phase == PH_WR1) begin
            phase    = PH_WAIT;
            byte_idx = '0;
            shreg    = '0;
          end else begin
            start_write(PH_READ, 8'h00);
          end
        end
      end
      PH_WAIT: begin
        phase = PH_RST2;
        shreg = '0;
      end
      PH_READ: begin
        bit_idx = bit_idx + 3'd1;
        if (bit_idx == '0) begin
          if (byte_idx == 4'd0) temp_lo = shreg;
          else if (byte_idx == 4'd1) temp_hi = shreg;
          if (int'(byte_idx) + 1 >= N_BYTES) begin
            finish_read(1'b1);
            return 1'b1;
          end
          byte_idx = byte_idx + 4'd1;
          shreg    = '0;
        end
      end
      default: finish_read(1'b0);
    endcase
    return 1'b0;
  endfunction

  function automatic result_t advance_sequencer(logic start, logic lvl);
    result_t r;
    logic    drv;
    logic    done;
    done = 1'b0;
    if (start) begin
      if (phase == PH_IDLE) begin
        phase    = PH_RST1;
        usec     = '0;
        bit_idx  = '0;
        byte_idx = '0;
        shreg    = '0;
      end
      drv = bus_driven();
    end else begin
      drv = bus_driven();
      if (phase != PH_IDLE) begin
        if ((phase == PH_RST1 || phase == PH_RST2) && usec == RST_SAMPLE)
          shreg = {7'b0, lvl};
        else if (phase == PH_READ && usec == RD_SAMPLE)
          shreg = {lvl, shreg[7:1]};
        usec = usec + 1'b1;
        if (usec >= slot_ticks() || usec == '0)
          done = close_slot();
      end
    end
    r.drive_low       = drv;
    r.busy_res        = (phase != PH_IDLE);
    r.done_res        = done;
    r.read_ok         = last_ok;
    r.temperature_raw = {temp_hi, temp_lo};
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at result %0d: %s", n_checked, msg);
    fail_count = fail_count + 1;
  endtask

  task automatic check_field(string name, int got, int exp_v);
    if (got != exp_v)
      report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, exp_v));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase     = PH_IDLE;
      usec      = '0;
      bit_idx   = '0;
      byte_idx  = '0;
      shreg     = '0;
      temp_lo   = '0;
      temp_hi   = '0;
      last_ok   = 1'b0;
      conv_wait = DEF_CONV_WAIT;
      reader_results_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reader_results_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = reader_results_q.pop_front();
          check_field("drive_low", out_drive_low, want.drive_low);
          check_field("busy_res", out_busy_res, want.busy_res);
          check_field("done_res", out_done_res, want.done_res);
          check_field("read_ok", out_read_ok, want.read_ok);
          check_field("temperature_raw", int'(out_temperature_raw),
                      int'(want.temperature_raw));
        end
        n_checked++;
      end
      if (cfg_valid && cfg_ready)
        conv_wait = cfg_conversion_wait_us;
      if (in_valid && in_ready)
        reader_results_q.push_back(advance_sequencer(in_action, in_line_level));
    end
    pending <= reader_results_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Testbench top: plays the sensor side of the bus and drives the reader item by item.
module testbench import owtr_pkg::*; ();

  // item kinds on the input channel
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  localparam int MAX_GAP   = 12;   // longest per-item idle on either side
  localparam int LONG_HOLD = 400;  // receiver hold-off, long enough to back up the input
  localparam int SETTLE    = 4;    // cycles allowed past the last result before a write
  localparam int RD_SLOTS  = 8 * DEF_BYTES;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid      = 1'b0;
  logic             in_action     = ACT_TICK;
  logic             in_line_level = 1'b0;
  logic             out_ready     = 1'b0;
  logic             cfg_valid     = 1'b0;
  logic [CNT_W-1:0] cfg_wait      = '0;

  logic               in_ready;
  logic               out_valid;
  logic               out_drive_low;
  logic               out_busy_res;
  logic               out_done_res;
  logic               out_read_ok;
  logic signed [15:0] out_temperature_raw;
  logic               cfg_ready;

  int pending;
  int fail_count;

  // idling modes, redrawn every so often by the sender
  bit tx_idle   = 1'b0;
  bit rx_idle   = 1'b0;
  bit long_hold = 1'b0;

  int items_sent   = 0;
  int full_reads   = 0;
  int absent_reads = 0;
  int cfg_writes   = 0;

  // conversion wait as last written; the sensor timeline depends on it
  logic [CNT_W-1:0] conv_now = DEF_CONV_WAIT;

  always #5 clk = ~clk;

  onewire_temperature_reader uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_action              (in_action),
    .in_line_level          (in_line_level),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_drive_low          (out_drive_low),
    .out_busy_res           (out_busy_res),
    .out_done_res           (out_done_res),
    .out_read_ok            (out_read_ok),
    .out_temperature_raw    (out_temperature_raw),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_conversion_wait_us (cfg_wait)
  );

  owtr_result_check result_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_action              (in_action),
    .in_line_level          (in_line_level),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_drive_low          (out_drive_low),
    .out_busy_res           (out_busy_res),
    .out_done_res           (out_done_res),
    .out_read_ok            (out_read_ok),
    .out_temperature_raw    (out_temperature_raw),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_conversion_wait_us (cfg_wait),
    .pending                (pending),
    .fail_count             (fail_count)
  );

  // Hang guard. Sized from the worst case: roughly 90k items, each waiting out
  // a full sender gap and a full receiver stall, plus the long hold-offs, x4.
  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side. Draws a stall per result; a requested long hold replaces
  // the draw once, so out_ready gets a single assignment per time step.
  initial begin : receiver
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        stall     = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        stall = rx_idle ? $urandom_range(MAX_GAP, 0) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One item on the input channel. Returns on the edge that accepted it and
  // leaves valid up, so the next call can follow back to back.
  task automatic send_item(input logic act, input logic lvl);
    int gap;
    gap = tx_idle ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_line_level <= lvl;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    // new idling mode every 150 items; about 40% of stretches run without gaps
    if (items_sent % 150 == 0) begin
      case ($urandom_range(4, 0))
        0, 1:    begin tx_idle = 1'b0; rx_idle = 1'b0; end
        2:       begin tx_idle = 1'b1; rx_idle = 1'b0; end
        3:       begin tx_idle = 1'b0; rx_idle = 1'b1; end
        default: begin tx_idle = 1'b1; rx_idle = 1'b1; end
      endcase
    end
  endtask

  // n ticks of bus time. The line is random noise except at tick sample_at,
  // where the sensor answers with sample_lvl. Now and then a start request
  // slips in; these are only used while a read is running, so they must be ignored.
  task automatic tick_span(input int n, input int sample_at, input logic sample_lvl);
    for (int t = 0; t < n; t++) begin
      if ($urandom_range(399, 0) == 0)
        send_item(ACT_START, 1'($urandom_range(1, 0)));
      send_item(ACT_TICK, (t == sample_at) ? sample_lvl : logic'($urandom_range(1, 0)));
    end
  endtask

  // Stop offering items and wait until every predicted result is back,
  // then a few more cycles so the block is surely quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_conv_wait(input logic [CNT_W-1:0] us);
    settle();
    cfg_valid <= 1'b1;
    cfg_wait  <= us;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    conv_now = us;
    cfg_writes++;
  endtask

  // One read as the sensor sees it. ok1/ok2 decide whether a presence pulse
  // answers each bus reset; pad holds the scratchpad, byte 0 in the low bits,
  // each byte sent LSB first. A missing presence ends the read after that reset.
  task automatic run_read(input bit ok1, input bit ok2,
                          input logic [8*DEF_BYTES-1:0] pad);
    send_item(ACT_START, 1'($urandom_range(1, 0)));
    send_item(ACT_START, 1'($urandom_range(1, 0)));   // second request lands while busy
    tick_span(int'(RST_LEN), int'(RST_SAMPLE), !ok1);
    if (!ok1) begin
      absent_reads++;
    end else begin
      // skip-ROM and convert: two bytes of write slots
      tick_span(16 * int'(SLOT_LEN), -1, 1'b0);
      // a zero wait still occupies one tick
      tick_span((conv_now == '0) ? 1 : int'(conv_now), -1, 1'b0);
      tick_span(int'(RST_LEN), int'(RST_SAMPLE), !ok2);
      if (!ok2) begin
        absent_reads++;
      end else begin
        // skip-ROM and read-scratchpad, then the scratchpad bits one per slot
        tick_span(16 * int'(SLOT_LEN), -1, 1'b0);
        for (int s = 0; s < RD_SLOTS; s++)
          tick_span(int'(SLOT_LEN), int'(RD_SAMPLE), pad[s]);
        full_reads++;
      end
    end
    // the bus sits idle for a few ticks; these must not disturb anything
    repeat ($urandom_range(5, 0)) send_item(ACT_TICK, 1'($urandom_range(1, 0)));
  endtask

  initial begin : stimulus
    logic [8*DEF_BYTES-1:0] pad;
    logic [CNT_W-1:0]       wait_us;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // idle ticks with the line at both levels
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_TICK, 1'b1);
    send_item(ACT_TICK, 1'b0);

    // the conversion wait is far too long to run out, so the default setting and
    // the largest one are exercised with reads that find no sensor
    pad = {8'($urandom), $urandom, $urandom};
    run_read(1'b0, 1'b0, pad);
    write_conv_wait({CNT_W{1'b1}});
    run_read(1'b0, 1'b1, pad);

    // zero wait, most negative temperature
    write_conv_wait('0);
    pad = {$urandom, 24'($urandom), 16'h8000};
    run_read(1'b1, 1'b1, pad);

    // one-tick wait, most positive temperature
    write_conv_wait(CNT_W'(1));
    pad = {$urandom, 24'($urandom), 16'h7FFF};
    run_read(1'b1, 1'b1, pad);

    // second presence missing: temperature must keep the previous value
    pad = {8'($urandom), $urandom, $urandom};
    run_read(1'b1, 1'b0, pad);

    // --- random reads ---
    for (int r = 0; r < 6; r++) begin
      case ($urandom_range(3, 0))
        0:       wait_us = CNT_W'($urandom_range(3, 0));
        1, 2:    wait_us = CNT_W'($urandom_range(300, 0));
        default: wait_us = CNT_W'($urandom_range(2000, 0));
      endcase
      write_conv_wait(wait_us);
      // back the block up behind a stalled receiver on the first two reads
      if (r < 2) long_hold = 1'b1;
      pad = {8'($urandom), $urandom, $urandom};
      run_read($urandom_range(9, 0) != 0, $urandom_range(9, 0) != 0, pad);
    end

    settle();
    $display("Covered %0d items over %0d conversion wait settings.", items_sent, cfg_writes);
    $display("%0d reads ran to the end, %0d stopped on a missing presence pulse.",
             full_reads, absent_reads);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/owtr_pkg.sv
hw/rtl/owtr_step.sv
hw/rtl/owtr_out_reg.sv
hw/rtl/onewire_temperature_reader.sv
hw/rtl/owtr_checker.sv
verif/owtr_result_check.sv
verif/testbench.sv
